### rtl/core/u8d_pkg.sv
package u8d_pkg;

  localparam int unsigned CodeW   = 21;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned StatusW = 3;

  localparam logic [CodeW-1:0] ReplacementReset = 21'h00FFFD;

  // Decode phase. The same encoding is reported as the result status.
  typedef enum logic [StatusW-1:0] {
    PH_START   = 3'd0,
    PH_ACCEPT  = 3'd1,
    PH_REJECT  = 3'd2,
    PH_EXPECT1 = 3'd3,
    PH_EXPECT2 = 3'd4,
    PH_EXPECT3 = 3'd5
  } phase_t;

  typedef enum logic {
    CMD_FEED  = 1'b0,
    CMD_RESET = 1'b1
  } command_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [CodeW-1:0]   code_point;
  } out_item_t;

  typedef struct packed {
    phase_t           next_phase;
    logic [CodeW-1:0] next_partial;
    out_item_t        item;
  } step_res_t;

endpackage

### rtl/core/utf8_byte_stream_decoder.sv
// Channel   | Ports                                   | Direction
// ----------+-----------------------------------------+----------
// input     | in_valid, in_ready, in_command,         | in
//           | in_data_byte                            |
// result    | out_valid, out_ready, out_status,       | out
//           | out_code_point                          |
// config    | cfg_we, cfg_wdata (replacement code)    | in
//
// Each request updates the decode phase and partial code point at the accepting edge, and
// its result goes into a two-entry output queue, so a request can be accepted on every
// cycle while the queue is not full. A result is offered once those ahead of it are taken.
// in_ready drops only while both queue entries hold results the receiver has not taken.
// Reset (synchronous, active low) returns the decoder to the start phase, clears the
// partial code point, empties the queue and loads the replacement code with U+FFFD.
module utf8_byte_stream_decoder
  import u8d_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,

  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_command,
  input  logic [ByteW-1:0]   in_data_byte,

  output logic               out_valid,
  input  logic               out_ready,
  output logic [StatusW-1:0] out_status,
  output logic [CodeW-1:0]   out_code_point,

  input  logic               cfg_we,
  input  logic [CodeW-1:0]   cfg_wdata
);

  phase_t           phase_r;
  phase_t           phase_nxt;
  logic [CodeW-1:0] partial_r;
  logic [CodeW-1:0] partial_nxt;
  logic [CodeW-1:0] replacement_r;
  logic [CodeW-1:0] replacement_nxt;
  step_res_t        step;
  out_item_t        head;
  logic             q_full;
  logic             accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Decode logic: next phase, next partial code point and the result for
  // the byte currently presented.
  u8d_step u_step (
    .phase       (phase_r),
    .partial     (partial_r),
    .replacement (replacement_r),
    .command     (in_command),
    .data_byte   (in_data_byte),
    .res         (step)
  );

  // State only advances when a request is actually taken.
  always_comb begin
    phase_nxt       = accept ? step.next_phase : phase_r;
    partial_nxt     = accept ? step.next_partial : partial_r;
    replacement_nxt = cfg_we ? cfg_wdata : replacement_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_START;
      partial_r     <= '0;
      replacement_r <= ReplacementReset;
    end else begin
      phase_r       <= phase_nxt;
      partial_r     <= partial_nxt;
      replacement_r <= replacement_nxt;
    end
  end

  // Result queue decouples the two handshakes.
  u8d_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_item (step.item),
    .full      (q_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (head)
  );

  assign out_status     = head.status;
  assign out_code_point = head.code_point;

endmodule

### rtl/core/u8d_step.sv
module u8d_step
  import u8d_pkg::*;
(
  input  phase_t           phase,
  input  logic [CodeW-1:0] partial,
  input  logic [CodeW-1:0] replacement,
  input  logic             command,
  input  logic [ByteW-1:0] data_byte,
  output step_res_t        res
);

  phase_t           ph_nxt;
  logic [CodeW-1:0] part_nxt;
  logic             is_cont;

  assign is_cont = (data_byte[7:6] == 2'b10);

  always_comb begin
    ph_nxt   = phase;
    part_nxt = partial;
    if (command == CMD_RESET) begin
      ph_nxt = PH_START;
    end else begin
      case (phase)
        PH_START, PH_ACCEPT, PH_REJECT: begin
          // A new lead byte is expected here.
          if (data_byte == 8'hC0 || data_byte == 8'hC1) begin
            ph_nxt = PH_REJECT;
          end else if (data_byte[7] == 1'b0) begin
            part_nxt = {13'd0, data_byte};
            ph_nxt   = PH_ACCEPT;
          end else if (is_cont) begin
            ph_nxt = PH_START;
          end else if (data_byte[7:5] == 3'b110) begin
            part_nxt = {10'd0, data_byte[4:0], 6'd0};
            ph_nxt   = PH_EXPECT1;
          end else if (data_byte[7:4] == 4'b1110) begin
            part_nxt = {5'd0, data_byte[3:0], 12'd0};
            ph_nxt   = PH_EXPECT2;
          end else if (data_byte[7:3] == 5'b11110) begin
            part_nxt = {data_byte[2:0], 18'd0};
            ph_nxt   = PH_EXPECT3;
          end else begin
            ph_nxt = PH_REJECT;
          end
        end
        PH_EXPECT3: begin
          part_nxt = partial | {3'd0, data_byte[5:0], 12'd0};
          ph_nxt   = is_cont ? PH_EXPECT2 : PH_REJECT;
        end
        PH_EXPECT2: begin
          part_nxt = partial | {9'd0, data_byte[5:0], 6'd0};
          ph_nxt   = is_cont ? PH_EXPECT1 : PH_REJECT;
        end
        PH_EXPECT1: begin
          part_nxt = partial | {15'd0, data_byte[5:0]};
          ph_nxt   = is_cont ? PH_ACCEPT : PH_REJECT;
        end
        default: begin
          ph_nxt = PH_REJECT;
        end
      endcase
    end
  end

  always_comb begin
    res.next_phase      = ph_nxt;
    res.next_partial    = part_nxt;
    res.item.status     = ph_nxt;
    res.item.code_point = (ph_nxt == PH_ACCEPT) ? part_nxt : replacement;
  end

endmodule

### rtl/core/u8d_out_fifo.sv
module u8d_out_fifo
  import u8d_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  out_item_t push_item,
  output logic      full,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  out_item_t   slot_r [2];
  logic        wr_ptr_r;
  logic        wr_ptr_nxt;
  logic        rd_ptr_r;
  logic        rd_ptr_nxt;
  logic [1:0]  count_r;
  logic [1:0]  count_nxt;
  logic        pop;

  assign full      = (count_r == 2'd2);
  assign out_valid = (count_r != 2'd0);
  assign out_item  = slot_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  // The occupancy never goes past the two slots.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("output queue count out of range");

  // Nothing is pushed into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("push into full output queue");

  // Pointer distance always matches the occupancy, modulo two.
  a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r ^ rd_ptr_r) == count_r[0])
    else $error("queue pointers disagree with count");

  // A push without a pop grows the queue by one request.
  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 2'd1))
    else $error("queue count did not grow on push");

endmodule
